>>> sv/spq_pkg.sv
// Package for the sorted priority queue: transaction structs, the entry record,
// the cell control struct and the status codes.
// Depends on nothing; used by spq_cell and sorted_priority_queue_top.
package spq_pkg;

	// Status codes reported with every result.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// Operation codes carried in the kind field.
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	// One command transaction.
	typedef struct packed {
		logic               kind;
		logic signed [31:0] value;
		logic        [7:0]  prio;
	} in_item_t;

	// One result transaction.
	typedef struct packed {
		logic signed [31:0] removed_value;
		logic        [1:0]  status;
		logic signed [31:0] head_value;
		logic               is_empty;
		logic        [4:0]  fill;
	} out_item_t;

	// Contents of one queue slot.
	typedef struct packed {
		logic signed [31:0] value;
		logic        [7:0]  prio;
	} entry_t;

	// Operation broadcast to every cell; at most one is set.
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

>>> sv/spq_cell.sv
// One slot of the sorted cell chain: holds an entry and decides each cycle
// whether to keep it, take the new entry, or take a neighbour's entry.
// Depends on spq_pkg.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  spq_pkg::entry_t    new_entry,
	input  logic               occupied,
	input  logic               prev_new_ahead,
	input  spq_pkg::entry_t    prev_entry,
	input  spq_pkg::entry_t    next_entry,
	output logic               new_ahead,
	output spq_pkg::entry_t    entry
);

	spq_pkg::entry_t entry_q;
	spq_pkg::entry_t entry_d;

	// The new entry belongs in front of this slot when the slot is empty or holds
	// a strictly larger priority; equal priorities stay ahead of the newcomer.
	assign new_ahead = !occupied || (entry_q.prio > new_entry.prio);

	// Slot update: on insert take the new entry at the insertion point and shift down below it; shift up on remove.
	always_comb begin
		entry_d = entry_q;
		if (ctl.ins) begin
			if (prev_new_ahead) begin
				entry_d = prev_entry;
			end else if (new_ahead) begin
				entry_d = new_entry;
			end
		end else if (ctl.rem) begin
			entry_d = next_entry;
		end
	end

	// Payload register; no reset as contents are only read below the fill count.
	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

>>> sv/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: a chain of spq_cell slots, the fill
// count and the result register.
// Depends on spq_pkg and spq_cell.
//
//  channel   handshake          payload                 direction
//  command   start / busy       item   (in_item_t)      in
//  result    done strobe        result (out_item_t)     out
//
// A command is taken on any edge where start is high; busy is always low, so a
// command may follow in every cycle. All slots compare against the new priority
// at once and shift in the same cycle, and the result of each command appears
// on the following cycle for one cycle.
// Reset clears the fill count, the status and the result strobe; slot contents need none.
// The receiver cannot stall, so results are never held back.
module sorted_priority_queue_top #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  spq_pkg::in_item_t  item,
	output logic               done,
	output spq_pkg::out_item_t result
);

	localparam int FW = $clog2(DEPTH + 1);

	logic [FW-1:0]       fill_q;
	logic                accept;
	logic                is_full;
	logic                is_empty_now;
	logic                ins_ok;
	logic                rem_ok;
	spq_pkg::cell_ctl_t  ctl;
	spq_pkg::entry_t     new_entry;
	spq_pkg::entry_t     entries [DEPTH];
	logic [DEPTH-1:0]    new_ahead;

	logic                done_q;
	logic [1:0]          status_q;
	logic signed [31:0]  removed_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Operation decode with the full and empty guards.
	assign is_full      = (fill_q == FW'(DEPTH));
	assign is_empty_now = (fill_q == '0);
	assign ins_ok       = accept && (item.kind == spq_pkg::KIND_INSERT) && !is_full;
	assign rem_ok       = accept && (item.kind == spq_pkg::KIND_REMOVE) && !is_empty_now;
	assign ctl.ins      = ins_ok;
	assign ctl.rem      = rem_ok;

	assign new_entry.value = item.value;
	assign new_entry.prio  = item.prio;

	// The cell chain, head at index zero.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic            occ;
		logic            prev_b;
		spq_pkg::entry_t prev_e;
		spq_pkg::entry_t next_e;

		assign occ = (FW'(i) < fill_q);

		if (i == 0) begin : g_first
			assign prev_b = 1'b0;
			assign prev_e = new_entry;
		end else begin : g_mid
			assign prev_b = new_ahead[i-1];
			assign prev_e = entries[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_e = '0;
		end else begin : g_inner
			assign next_e = entries[i+1];
		end

		spq_cell u_cell (
			.clk            (clk),
			.ctl            (ctl),
			.new_entry      (new_entry),
			.occupied       (occ),
			.prev_new_ahead (prev_b),
			.prev_entry     (prev_e),
			.next_entry     (next_e),
			.new_ahead      (new_ahead[i]),
			.entry          (entries[i])
		);
	end

	// Fill count and the registered part of the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			done_q   <= 1'b0;
			status_q <= spq_pkg::ST_OK;
		end else begin
			done_q <= accept;
			if (ins_ok) begin
				fill_q <= fill_q + 1'b1;
			end else if (rem_ok) begin
				fill_q <= fill_q - 1'b1;
			end
			if (accept) begin
				if (item.kind == spq_pkg::KIND_INSERT) begin
					status_q <= is_full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
				end else begin
					status_q <= is_empty_now ? spq_pkg::ST_UNDERFLOW : spq_pkg::ST_OK;
				end
			end
		end
	end

	// The removed word is the head before the shift.
	always_ff @(posedge clk) begin
		if (accept) begin
			removed_q <= rem_ok ? entries[0].value : 32'sd0;
		end
	end

	// Head, empty flag and count come from the state after the transaction.
	assign done                 = done_q;
	assign result.removed_value = removed_q;
	assign result.status        = status_q;
	assign result.head_value    = (fill_q == '0) ? 32'sd0 : entries[0].value;
	assign result.is_empty      = (fill_q == '0);
	assign result.fill          = 5'(fill_q);

endmodule
